FILE: rtl/e2q_pkg.sv
package e2q_pkg;

    localparam int CordicStages = 16;
    localparam int AngleW = 16;
    localparam int CompW = 16;
    // CORDIC datapath: x and y in Q.30 with headroom, z in degrees with 16 fraction bits.
    localparam int XyW = 33;
    localparam int ZW = 26;
    localparam int TrigW = 18;
    localparam int ProdW = 36;
    localparam int TripW = 54;
    localparam int SumW = 55;
    localparam int CompMax = 32767;

    localparam logic signed [XyW-1:0] GainQ30 = 33'sd652032874;
    localparam logic signed [ZW-1:0] Deg90 = 26'sd5898240;
    localparam logic signed [ZW-1:0] Deg180 = 26'sd11796480;

    typedef logic signed [XyW-1:0] xy_t;
    typedef logic signed [ZW-1:0] z_t;
    typedef logic signed [TrigW-1:0] trig_t;

    function automatic z_t atan_deg(input int idx);
        z_t r;
        case (idx)
            0: r = 26'sd2949120;
            1: r = 26'sd1740967;
            2: r = 26'sd919879;
            3: r = 26'sd466945;
            4: r = 26'sd234379;
            5: r = 26'sd117304;
            6: r = 26'sd58666;
            7: r = 26'sd29335;
            8: r = 26'sd14668;
            9: r = 26'sd7334;
            10: r = 26'sd3667;
            11: r = 26'sd1833;
            12: r = 26'sd917;
            13: r = 26'sd458;
            14: r = 26'sd229;
            15: r = 26'sd115;
            16: r = 26'sd57;
            17: r = 26'sd29;
            18: r = 26'sd14;
            19: r = 26'sd7;
            20: r = 26'sd4;
            21: r = 26'sd2;
            22: r = 26'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/euler_to_quaternion_remap_top.sv
// Channel   | Ports                        | tdata fields (low bit up)
// s (input) | s_axis_tvalid/tready/tdata   | roll, pitch, yaw (16 b each)
// m (out)   | m_axis_tvalid/tready/tdata   | first, second, third, fourth (16 b each)
// cfg       | cfg_wr_en, cfg_wr_data       | head_tracking_mode
// One word per cycle unless the output stalls. Stages: range reduction, the
// unrolled CORDIC stages, rounding, two product stages, sum and round/remap.
// Synchronous active-low reset clears the valid bits and the mode register.
// The whole pipeline advances only when the last stage is empty or taken.
module euler_to_quaternion_remap_top
    import e2q_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // roll, pitch, yaw
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // first, second, third, fourth
);

    localparam int NS = CordicStages + 6;

    logic mode_reg;
    logic [NS-1:0] vld_reg;
    logic adv;

    assign adv = !vld_reg[NS-1] || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = vld_reg[NS-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
            vld_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                mode_reg <= cfg_wr_data;
            end
            if (adv) begin
                vld_reg <= {vld_reg[NS-2:0], s_axis_tvalid};
            end
        end
    end

    // Stage 0: half angle and range reduction.
    xy_t x_reg [3][CordicStages+1];
    xy_t y_reg [3][CordicStages+1];
    z_t  z_reg [3][CordicStages+1];
    logic flip_reg [3][CordicStages+1];

    for (genvar a = 0; a < 3; a++) begin : g_ang
        z_t z0;
        assign z0 = z_t'($signed(s_axis_tdata[a*AngleW +: AngleW])) <<< 8;
        always_ff @(posedge aclk) begin
            if (adv) begin
                x_reg[a][0] <= GainQ30;
                y_reg[a][0] <= '0;
                if (z0 > Deg90) begin
                    z_reg[a][0] <= z0 - Deg180;
                    flip_reg[a][0] <= 1'b1;
                end else if (z0 < -Deg90) begin
                    z_reg[a][0] <= z0 + Deg180;
                    flip_reg[a][0] <= 1'b1;
                end else begin
                    z_reg[a][0] <= z0;
                    flip_reg[a][0] <= 1'b0;
                end
            end
        end
        for (genvar i = 0; i < CordicStages; i++) begin : g_cs
            xy_t dx, dy;
            assign dx = y_reg[a][i] >>> i;
            assign dy = x_reg[a][i] >>> i;
            always_ff @(posedge aclk) begin
                if (adv) begin
                    flip_reg[a][i+1] <= flip_reg[a][i];
                    if (!z_reg[a][i][ZW-1]) begin
                        x_reg[a][i+1] <= x_reg[a][i] - dx;
                        y_reg[a][i+1] <= y_reg[a][i] + dy;
                        z_reg[a][i+1] <= z_reg[a][i] - atan_deg(i);
                    end else begin
                        x_reg[a][i+1] <= x_reg[a][i] + dx;
                        y_reg[a][i+1] <= y_reg[a][i] - dy;
                        z_reg[a][i+1] <= z_reg[a][i] + atan_deg(i);
                    end
                end
            end
        end
    end

    // Round to Q.16 and apply the flip.
    trig_t s_reg [3];
    trig_t c_reg [3];
    for (genvar a = 0; a < 3; a++) begin : g_rnd
        xy_t xr, yr;
        trig_t cx, sy;
        assign xr = (x_reg[a][CordicStages] + xy_t'(8192)) >>> 14;
        assign yr = (y_reg[a][CordicStages] + xy_t'(8192)) >>> 14;
        assign cx = xr[TrigW-1:0];
        assign sy = yr[TrigW-1:0];
        always_ff @(posedge aclk) begin
            if (adv) begin
                c_reg[a] <= flip_reg[a][CordicStages] ? -cx : cx;
                s_reg[a] <= flip_reg[a][CordicStages] ? -sy : sy;
            end
        end
    end

    // Pair products of roll and pitch, then triples with yaw.
    logic signed [ProdW-1:0] cc_reg, ss_reg, sc_reg, cs_reg;
    trig_t sy_reg, cy_reg;
    logic signed [TripW-1:0] t_reg [8];
    always_ff @(posedge aclk) begin
        if (adv) begin
            cc_reg <= c_reg[0] * c_reg[1];
            ss_reg <= s_reg[0] * s_reg[1];
            sc_reg <= s_reg[0] * c_reg[1];
            cs_reg <= c_reg[0] * s_reg[1];
            sy_reg <= s_reg[2];
            cy_reg <= c_reg[2];
            t_reg[0] <= cc_reg * cy_reg;
            t_reg[1] <= ss_reg * sy_reg;
            t_reg[2] <= sc_reg * cy_reg;
            t_reg[3] <= cs_reg * sy_reg;
            t_reg[4] <= cs_reg * cy_reg;
            t_reg[5] <= sc_reg * sy_reg;
            t_reg[6] <= cc_reg * sy_reg;
            t_reg[7] <= ss_reg * cy_reg;
        end
    end

    logic signed [SumW-1:0] sum_reg [4];
    always_ff @(posedge aclk) begin
        if (adv) begin
            sum_reg[0] <= SumW'(t_reg[0]) + SumW'(t_reg[1]);
            sum_reg[1] <= SumW'(t_reg[2]) - SumW'(t_reg[3]);
            sum_reg[2] <= SumW'(t_reg[4]) + SumW'(t_reg[5]);
            sum_reg[3] <= SumW'(t_reg[6]) + SumW'(t_reg[7]);
        end
    end

    logic signed [CompW-1:0] q [4];
    for (genvar k = 0; k < 4; k++) begin : g_sat
        logic signed [SumW-1:0] r;
        assign r = (sum_reg[k] + (SumW'(1) <<< 32)) >>> 33;
        always_comb begin
            if (r > SumW'(CompMax)) begin
                q[k] = CompW'(CompMax);
            end else if (r < -SumW'(CompMax)) begin
                q[k] = -CompW'(CompMax);
            end else begin
                q[k] = r[CompW-1:0];
            end
        end
    end

    logic [63:0] out_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            if (mode_reg) begin
                out_reg <= {-q[0], -q[1], -q[3], q[2]};
            end else begin
                out_reg <= {q[3], q[2], q[1], q[0]};
            end
        end
    end
    assign m_axis_tdata = out_reg;

`ifndef SYNTHESIS
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed under stall");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("pipeline stalled while output empty");
    a_no_min: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[15:0] != 16'h8000)
        else $error("component reached -32768");
`endif

endmodule

FILE: tb/tb_euler_to_quaternion_remap_top.sv
class quat_scoreboard;
    bit          head_mode;
    logic [63:0] quat_fifo[$];
    int          errors;

    local const longint atan_lut[24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    function new();
        head_mode = 0;
        errors = 0;
    endfunction

    // Sine and cosine in Q.16 of half of the raw angle.
    function void half_sincos(input longint ang, output longint sn, output longint cs);
        longint z;
        longint x;
        longint y;
        longint dx;
        longint dy;
        bit     flip;
        z = ang * 256;
        x = 652032874;
        y = 0;
        flip = 0;
        if (z > 90 * 65536) begin
            z -= 180 * 65536;
            flip = 1;
        end else if (z < -90 * 65536) begin
            z += 180 * 65536;
            flip = 1;
        end
        for (int i = 0; i < e2q_pkg::CordicStages && i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= atan_lut[i];
            end else begin
                x += dx;
                y -= dy;
                z += atan_lut[i];
            end
        end
        x = (x + 8192) >>> 14;
        y = (y + 8192) >>> 14;
        if (flip) begin
            x = -x;
            y = -y;
        end
        cs = x;
        sn = y;
    endfunction

    function longint round_sat(input longint sum48);
        longint v;
        v = (sum48 + (longint'(1) << 32)) >>> 33;
        if (v > 32767) v = 32767;
        if (v < -32767) v = -32767;
        return v;
    endfunction

    function void note_angles(input logic [47:0] word);
        longint sr, cr, sp, cp, sy, cy;
        longint qw, qx, qy, qz;
        logic [15:0] c0, c1, c2, c3;
        half_sincos(longint'($signed(word[15:0])), sr, cr);
        half_sincos(longint'($signed(word[31:16])), sp, cp);
        half_sincos(longint'($signed(word[47:32])), sy, cy);
        qw = round_sat(cr * cp * cy + sr * sp * sy);
        qx = round_sat(sr * cp * cy - cr * sp * sy);
        qy = round_sat(cr * sp * cy + sr * cp * sy);
        qz = round_sat(cr * cp * sy + sr * sp * cy);
        if (head_mode) begin
            c0 = 16'(qy);
            c1 = 16'(-qz);
            c2 = 16'(-qx);
            c3 = 16'(-qw);
        end else begin
            c0 = 16'(qw);
            c1 = 16'(qx);
            c2 = 16'(qy);
            c3 = 16'(qz);
        end
        quat_fifo.push_back({c3, c2, c1, c0});
    endfunction

    function void check_quat(input logic [63:0] word);
        logic [63:0] exp_word;
        string       names[4];
        names = '{"quat_first", "quat_second", "quat_third", "quat_fourth"};
        if (quat_fifo.size() == 0) begin
            $error("unexpected result word %h", word);
            errors++;
            return;
        end
        exp_word = quat_fifo.pop_front();
        for (int k = 0; k < 4; k++) begin
            if (word[16*k +: 16] !== exp_word[16*k +: 16]) begin
                $error("%s: expected %0d, got %0d", names[k],
                       $signed(exp_word[16*k +: 16]), $signed(word[16*k +: 16]));
                errors++;
            end
        end
    endfunction
endclass

module tb_euler_to_quaternion_remap_top
    import e2q_pkg::*;
();

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_wr_en = 0;
    logic        cfg_wr_data = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;   // roll, pitch, yaw
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [63:0] m_axis_tdata;        // first, second, third, fourth
    bit          steady = 0;

    quat_scoreboard quat_sb = new();

    euler_to_quaternion_remap_top dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        #1200000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) quat_sb.note_angles(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) quat_sb.check_quat(m_axis_tdata);
        end
    end

    initial begin
        int g;
        @(negedge aclk);
        forever begin
            m_axis_tready = 1;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
            g = pick_gap();
            if (g > 0) begin
                m_axis_tready = 0;
                repeat (g) @(negedge aclk);
            end
        end
    end

    task automatic send_angles(input logic [15:0] roll, input logic [15:0] pitch,
                               input logic [15:0] yaw);
        int g;
        g = pick_gap();
        if (g > 0) begin
            s_axis_tvalid = 0;
            repeat (g) @(negedge aclk);
        end
        s_axis_tvalid = 1;
        s_axis_tdata = {yaw, pitch, roll};
        do @(posedge aclk); while (!s_axis_tready);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_axis_tvalid = 0;
        while (quat_sb.quat_fifo.size() != 0) @(negedge aclk);
        repeat (CordicStages + 12) @(negedge aclk);
    endtask

    task automatic write_mode(input bit mode);
        cfg_wr_en = 1;
        cfg_wr_data = mode;
        @(negedge aclk);
        cfg_wr_en = 0;
        quat_sb.head_mode = mode;
    endtask

    function automatic logic [15:0] rand_angle();
        if ($urandom_range(0, 9) < 7) return 16'($signed($urandom_range(0, 46080)) - 23040);
        return 16'($urandom);
    endfunction

    task automatic random_burst(input int count, input bit with_pause);
        for (int i = 0; i < count; i++) begin
            if (with_pause && i == count / 2) drain();
            send_angles(rand_angle(), rand_angle(), rand_angle());
        end
    endtask

    initial begin
        logic [15:0] corner[10];
        corner = '{16'd0, 16'd23040, -16'sd23040, 16'd23041, -16'sd23041,
                   16'd11520, 16'h7fff, 16'h8000, 16'd1, 16'hffff};
        repeat (5) @(negedge aclk);
        aresetn = 1;
        @(negedge aclk);

        // Corner angles: zero, plus and minus one, 90 degrees, the half-angle boundary at
        // 180 degrees and just past it, and the ends of the 16-bit range.
        for (int i = 0; i < 10; i++) send_angles(corner[i], corner[(i + 3) % 10],
                                                 corner[(i + 7) % 10]);
        drain();
        write_mode(1);
        for (int i = 0; i < 10; i++) send_angles(corner[(i + 5) % 10], corner[i],
                                                 corner[(i + 2) % 10]);
        drain();
        write_mode(0);
        random_burst(160, 1);
        drain();
        write_mode(1);
        steady = 1;
        random_burst(160, 0);
        steady = 0;
        drain();
        write_mode(0);
        random_burst(150, 0);
        drain();
        write_mode(1);
        random_burst(160, 0);
        drain();

        if (quat_sb.errors == 0 && quat_sb.quat_fifo.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

FILE: euler_to_quaternion_remap_top.f
rtl/e2q_pkg.sv
rtl/euler_to_quaternion_remap_top.sv
tb/tb_euler_to_quaternion_remap_top.sv
